>>> rtl/kmp_pkg.sv
// Package: sizes, codes and the request/response types of the KMP matcher.
`timescale 1ns / 1ps

package kmp_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int TEXT_MAX    = 65536;

    localparam int ADDR_W = $clog2(PATTERN_MAX);
    localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int POS_W  = $clog2(TEXT_MAX + 1);
    localparam int MS_W   = 16;

    localparam logic [1:0] ACT_APPEND  = 2'd0;
    localparam logic [1:0] ACT_TEXT    = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;
    localparam logic [1:0] ACT_RESTART = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOPAT = 2'd2;
    localparam logic [1:0] ST_LONG  = 2'd3;

    localparam logic [1:0] OP_WALK  = 2'd0;
    localparam logic [1:0] OP_FAIL  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    typedef struct packed {
        logic             go;
        logic [1:0]       op;
        logic [LEN_W-1:0] arg;
        logic [7:0]       data;
        logic [LEN_W-1:0] fval;
    } t_cmd;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] value;
    } t_rsp;

endpackage

>>> rtl/kmp_walk.sv
// Pattern and failure memories with the failure-link walk engine.
`timescale 1ns / 1ps

module kmp_walk
    import kmp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output t_rsp o_rsp
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_CMP  = 2'd1;
    localparam logic [1:0] C_FRD  = 2'd2;

    logic [7:0]       pat_mem  [PATTERN_MAX];
    logic [LEN_W-1:0] fail_mem [PATTERN_MAX];

    logic [1:0]       r_state, n_state;
    logic [LEN_W-1:0] r_k, n_k;
    logic [7:0]       r_byte, n_byte;
    logic             r_done, n_done;
    logic [LEN_W-1:0] r_value, n_value;
    logic [7:0]       r_pat_q;
    logic [LEN_W-1:0] r_fail_q;

    logic [ADDR_W-1:0] probe;
    logic              wr_en;

    // Probe entry k: pattern[k] and failure[k-1] come back together.
    always_comb begin
        if (r_state == C_IDLE) begin
            probe = i_cmd.arg[ADDR_W-1:0];
        end else begin
            probe = r_fail_q[ADDR_W-1:0];
        end
    end

    assign wr_en = (r_state == C_IDLE) && i_cmd.go && (i_cmd.op == OP_WRITE);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            pat_mem[i_cmd.arg[ADDR_W-1:0]]  <= i_cmd.data;
            fail_mem[i_cmd.arg[ADDR_W-1:0]] <= i_cmd.fval;
        end
        r_pat_q  <= pat_mem[probe];
        r_fail_q <= fail_mem[probe - ADDR_W'(1)];
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_byte  = r_byte;
        n_done  = 1'b0;
        n_value = r_value;
        case (r_state)
            C_IDLE: begin
                if (i_cmd.go) begin
                    n_k    = i_cmd.arg;
                    n_byte = i_cmd.data;
                    case (i_cmd.op)
                        OP_WALK:  n_state = C_CMP;
                        OP_FAIL:  n_state = C_FRD;
                        OP_WRITE: n_done  = 1'b1;
                        default:  n_done  = 1'b1;
                    endcase
                end
            end
            C_CMP: begin
                if (r_pat_q == r_byte) begin
                    n_done  = 1'b1;
                    n_value = r_k + LEN_W'(1);
                    n_state = C_IDLE;
                end else if (r_k == '0) begin
                    n_done  = 1'b1;
                    n_value = '0;
                    n_state = C_IDLE;
                end else begin
                    // fall back along the failure link, probe is already issued
                    n_k = r_fail_q;
                end
            end
            C_FRD: begin
                n_done  = 1'b1;
                n_value = r_fail_q;
                n_state = C_IDLE;
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_k     <= n_k;
        r_byte  <= n_byte;
        r_value <= n_value;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_value;

endmodule

>>> rtl/kmp_substring_match.sv
// Top level of the streaming Knuth-Morris-Pratt substring matcher.
`timescale 1ns / 1ps

// A transaction is taken at a rising edge with start high and busy low. Its single
// result is on the o_ ports for exactly one cycle, marked by o_valid, and cannot be
// held off. Clear, restart, a text byte after a match and items flagged by status
// (store full, no pattern, text too long) keep busy low. They return their result in
// the next cycle, so one such transaction fits in every cycle. Any other item returns
// its result in the cycle in which busy falls. A text byte keeps busy high while the
// walk engine compares it, one failure-link fallback at a time, and through a failure
// read when it completes a match. An append keeps busy high for a failure read, a walk
// and a write of byte and failure value (only the write for the first pattern byte).
// Each memory has a single read port: every fallback is one read and one compare.
module kmp_substring_match
    import kmp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_action,
    input  logic [7:0]       i_data_byte,
    output logic             o_valid,
    output logic             o_found,
    output logic [MS_W-1:0]  o_match_start,
    output logic [LEN_W-1:0] o_pattern_length,
    output logic [1:0]       o_status
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_AP_FAIL  = 3'd1;
    localparam logic [2:0] S_AP_WALK  = 3'd2;
    localparam logic [2:0] S_AP_WRITE = 3'd3;
    localparam logic [2:0] S_TX_WALK  = 3'd4;
    localparam logic [2:0] S_TX_FAIL  = 3'd5;

    logic [2:0]       r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    t_rsp             rsp;
    logic [7:0]       r_byte, n_byte;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_m, n_m;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_found, n_found;
    logic [MS_W-1:0]  r_fpos, n_fpos;
    logic [1:0]       r_status, n_status;
    logic             r_valid, n_valid;

    kmp_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (r_cmd),
        .o_rsp   (rsp)
    );

    always_comb begin
        n_state  = r_state;
        n_cmd    = '0;
        n_byte   = r_byte;
        n_len    = r_len;
        n_m      = r_m;
        n_pos    = r_pos;
        n_found  = r_found;
        n_fpos   = r_fpos;
        n_status = r_status;
        n_valid  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_byte   = i_data_byte;
                    n_status = ST_OK;
                    case (i_action)
                        ACT_APPEND: begin
                            if (r_len == LEN_W'(PATTERN_MAX)) begin
                                n_status = ST_FULL;
                                n_valid  = 1'b1;
                            end else if (r_len == '0) begin
                                n_cmd.go   = 1'b1;
                                n_cmd.op   = OP_WRITE;
                                n_cmd.data = i_data_byte;
                                n_state    = S_AP_WRITE;
                            end else begin
                                // fetch failure[len-1] to seed the walk
                                n_cmd.go  = 1'b1;
                                n_cmd.op  = OP_FAIL;
                                n_cmd.arg = r_len;
                                n_state   = S_AP_FAIL;
                            end
                        end
                        ACT_TEXT: begin
                            if (r_len == '0) begin
                                n_status = ST_NOPAT;
                                n_valid  = 1'b1;
                            end else if (r_pos >= POS_W'(TEXT_MAX)) begin
                                n_status = ST_LONG;
                                n_valid  = 1'b1;
                            end else if (r_found) begin
                                n_pos   = r_pos + POS_W'(1);
                                n_valid = 1'b1;
                            end else begin
                                n_cmd.go   = 1'b1;
                                n_cmd.op   = OP_WALK;
                                n_cmd.arg  = (r_m >= r_len) ? '0 : r_m;
                                n_cmd.data = i_data_byte;
                                n_state    = S_TX_WALK;
                            end
                        end
                        ACT_CLEAR: begin
                            n_len   = '0;
                            n_m     = '0;
                            n_pos   = '0;
                            n_found = 1'b0;
                            n_fpos  = '0;
                            n_valid = 1'b1;
                        end
                        default: begin
                            n_m     = '0;
                            n_pos   = '0;
                            n_found = 1'b0;
                            n_fpos  = '0;
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_AP_FAIL: begin
                if (rsp.done) begin
                    n_cmd.go   = 1'b1;
                    n_cmd.op   = OP_WALK;
                    n_cmd.arg  = rsp.value;
                    n_cmd.data = r_byte;
                    n_state    = S_AP_WALK;
                end
            end
            S_AP_WALK: begin
                if (rsp.done) begin
                    n_cmd.go   = 1'b1;
                    n_cmd.op   = OP_WRITE;
                    n_cmd.arg  = r_len;
                    n_cmd.data = r_byte;
                    n_cmd.fval = rsp.value;
                    n_state    = S_AP_WRITE;
                end
            end
            S_AP_WRITE: begin
                if (rsp.done) begin
                    n_len   = r_len + LEN_W'(1);
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_TX_WALK: begin
                if (rsp.done) begin
                    if (rsp.value == r_len) begin
                        n_found   = 1'b1;
                        n_fpos    = r_pos[MS_W-1:0] + MS_W'(1) - MS_W'(r_len);
                        // after a full match, fall back to failure[len-1]
                        n_cmd.go  = 1'b1;
                        n_cmd.op  = OP_FAIL;
                        n_cmd.arg = r_len;
                        n_state   = S_TX_FAIL;
                    end else begin
                        n_m     = rsp.value;
                        n_pos   = r_pos + POS_W'(1);
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_TX_FAIL: begin
                if (rsp.done) begin
                    n_m     = rsp.value;
                    n_pos   = r_pos + POS_W'(1);
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cmd    <= '0;
            r_len    <= '0;
            r_m      <= '0;
            r_pos    <= '0;
            r_found  <= 1'b0;
            r_fpos   <= '0;
            r_status <= ST_OK;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cmd    <= n_cmd;
            r_len    <= n_len;
            r_m      <= n_m;
            r_pos    <= n_pos;
            r_found  <= n_found;
            r_fpos   <= n_fpos;
            r_status <= n_status;
            r_valid  <= n_valid;
        end
        r_byte <= n_byte;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_found          = r_found;
    assign o_match_start    = r_found ? r_fpos : '0;
    assign o_pattern_length = r_len;
    assign o_status         = r_status;

endmodule
